[hw/rtl/lwa_pkg.sv]
// Shared types and constants for the Lax-Wendroff advection step.
`timescale 1ns / 1ps

package lwa_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 15;

   // r - l needs one bit more than a sample, r - 2c + l two more.
   localparam int DIFF1_BITS = SAMPLE_BITS + 1;
   localparam int DIFF2_BITS = SAMPLE_BITS + 2;
   // Coefficients are unsigned, so they enter the signed product with a zero sign bit.
   localparam int PROD1_BITS = DIFF1_BITS + COEF_BITS + 1;
   localparam int PROD2_BITS = DIFF2_BITS + COEF_BITS + 1;
   localparam int SUM_BITS   = SAMPLE_BITS + 5;

   localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

   localparam logic [COEF_BITS-1:0] HALF_COURANT_RESET    = COEF_BITS'(1 << (COEF_BITS - 2));
   localparam logic [COEF_BITS-1:0] HALF_COURANT_SQ_RESET = COEF_BITS'(1 << (COEF_BITS - 3));

   // Register indexes of the control port.
   localparam logic CSR_HALF_COURANT    = 1'b0;
   localparam logic CSR_HALF_COURANT_SQ = 1'b1;

   // Results per queued entry: one, two or three.
   localparam logic [1:0] REPS_ONE   = 2'd1;
   localparam logic [1:0] REPS_TWO   = 2'd2;
   localparam logic [1:0] REPS_THREE = 2'd3;

   // The pointers wrap on their own, so the depth must be a power of two.
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value;
      logic [1:0]                    reps;
      logic                          row_last;
      logic                          short_row;
   } q_entry_type;

   typedef struct packed {
      logic                  not_empty;
      logic [Q_CNT_BITS-1:0] count;
   } q_status_type;

endpackage

[hw/rtl/lwa_front.sv]
// Front end: accepts samples, keeps the stencil window and computes each update.
`timescale 1ns / 1ps

module lwa_front import lwa_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_row_end,
   input  logic [COEF_BITS-1:0]          half_courant,
   input  logic [COEF_BITS-1:0]          half_courant_sq,
   input  q_status_type                  q_status,
   output logic                          push,
   output q_entry_type                   push_entry
);

   logic signed [SAMPLE_BITS-1:0] older_ff, older_in;
   logic signed [SAMPLE_BITS-1:0] newer_ff, newer_in;
   logic [1:0]                    seen_ff, seen_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic signed [DIFF1_BITS-1:0]  s1_d1_ff, s1_d1_in;
   logic signed [DIFF2_BITS-1:0]  s1_d2_ff, s1_d2_in;
   logic signed [SAMPLE_BITS-1:0] s1_centre_ff, s1_centre_in;
   logic [1:0]                    s1_reps_ff, s1_reps_in;
   logic                          s1_last_ff, s1_last_in;
   logic                          s1_short_ff, s1_short_in;

   logic                          s2_valid_ff;
   logic signed [PROD1_BITS-1:0]  s2_p1_ff, s2_p1_in;
   logic signed [PROD2_BITS-1:0]  s2_p2_ff, s2_p2_in;
   logic signed [SAMPLE_BITS-1:0] s2_centre_ff;
   logic [1:0]                    s2_reps_ff;
   logic                          s2_last_ff;
   logic                          s2_short_ff;

   logic                          accept;
   logic [Q_CNT_BITS:0]           committed;
   logic signed [COEF_BITS:0]     coef_h;
   logic signed [COEF_BITS:0]     coef_g;
   logic signed [SUM_BITS-1:0]    sum;
   logic signed [SAMPLE_BITS-1:0] sat_value;

   // Every slot the queue may be asked for is reserved before acceptance.
   assign committed = (Q_CNT_BITS + 1)'(q_status.count) + (Q_CNT_BITS + 1)'(s1_valid_ff)
                    + (Q_CNT_BITS + 1)'(s2_valid_ff);
   assign req_stall = committed >= (Q_CNT_BITS + 1)'(Q_DEPTH);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      older_in     = older_ff;
      newer_in     = newer_ff;
      seen_in      = seen_ff;
      s1_valid_in  = 1'b0;
      s1_d1_in     = DIFF1_BITS'(req_sample) - DIFF1_BITS'(older_ff);
      s1_d2_in     = DIFF2_BITS'(req_sample) - (DIFF2_BITS'(newer_ff) <<< 1)
                   + DIFF2_BITS'(older_ff);
      s1_centre_in = newer_ff;
      s1_reps_in   = REPS_ONE;
      s1_last_in   = req_row_end;
      s1_short_in  = 1'b0;
      if (accept) begin
         if (seen_ff < 2'd2) begin
            if (req_row_end) begin
               s1_valid_in = 1'b1;
               s1_short_in = 1'b1;
               older_in    = '0;
               newer_in    = '0;
               seen_in     = '0;
            end else begin
               older_in = newer_ff;
               newer_in = req_sample;
               seen_in  = seen_ff + 2'd1;
            end
         end else begin
            s1_valid_in = 1'b1;
            if (seen_ff == 2'd2) begin
               s1_reps_in = req_row_end ? REPS_THREE : REPS_TWO;
            end else begin
               s1_reps_in = req_row_end ? REPS_TWO : REPS_ONE;
            end
            if (req_row_end) begin
               older_in = '0;
               newer_in = '0;
               seen_in  = '0;
            end else begin
               older_in = newer_ff;
               newer_in = req_sample;
               seen_in  = 2'd3;
            end
         end
      end
   end

   assign coef_h  = $signed({1'b0, half_courant});
   assign coef_g  = $signed({1'b0, half_courant_sq});
   assign s2_p1_in = PROD1_BITS'(coef_h) * PROD1_BITS'(s1_d1_ff);
   assign s2_p2_in = PROD2_BITS'(coef_g) * PROD2_BITS'(s1_d2_ff);

   // Arithmetic shifts give floor rounding on the scaled products.
   assign sum = SUM_BITS'(s2_centre_ff) - SUM_BITS'(s2_p1_ff >>> COEF_BITS)
              + SUM_BITS'(s2_p2_ff >>> COEF_BITS);

   always_comb begin
      if (sum > SAT_HI) begin
         sat_value = SAT_HI[SAMPLE_BITS-1:0];
      end else if (sum < SAT_LO) begin
         sat_value = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         sat_value = sum[SAMPLE_BITS-1:0];
      end
   end

   assign push                 = s2_valid_ff;
   assign push_entry.value     = s2_short_ff ? '0 : sat_value;
   assign push_entry.reps      = s2_reps_ff;
   assign push_entry.row_last  = s2_last_ff;
   assign push_entry.short_row = s2_short_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff    <= '0;
         newer_ff    <= '0;
         seen_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         older_ff    <= older_in;
         newer_ff    <= newer_in;
         seen_ff     <= seen_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_d1_ff     <= s1_d1_in;
      s1_d2_ff     <= s1_d2_in;
      s1_centre_ff <= s1_centre_in;
      s1_reps_ff   <= s1_reps_in;
      s1_last_ff   <= s1_last_in;
      s1_short_ff  <= s1_short_in;
      s2_p1_ff     <= s2_p1_in;
      s2_p2_ff     <= s2_p2_in;
      s2_centre_ff <= s1_centre_ff;
      s2_reps_ff   <= s1_reps_ff;
      s2_last_ff   <= s1_last_ff;
      s2_short_ff  <= s1_short_ff;
   end

endmodule

[hw/rtl/lwa_queue.sv]
// Small queue of computed entries between the front and back ends.
`timescale 1ns / 1ps

module lwa_queue import lwa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  q_entry_type  push_entry,
   input  logic         pop,
   output q_entry_type  head,
   output q_status_type status
);

   q_entry_type           mem_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0] count_ff, count_in;

   assign wr_ptr_in = push ? wr_ptr_ff + Q_PTR_BITS'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + Q_PTR_BITS'(1) : rd_ptr_ff;
   assign count_in  = count_ff + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);

   assign head             = mem_ff[rd_ptr_ff];
   assign status.not_empty = count_ff != '0;
   assign status.count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   no_overflow : assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < Q_CNT_BITS'(Q_DEPTH))
      else $error("entry written into a full queue");

   no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("entry removed from an empty queue");

   count_matches_ptrs : assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_BITS'(Q_DEPTH)
      && (wr_ptr_ff - rd_ptr_ff) == count_ff[Q_PTR_BITS-1:0])
      else $error("queue count disagrees with its pointers");

endmodule

[hw/rtl/lwa_back.sv]
// Back end: expands each queued entry into its results and holds the output register.
`timescale 1ns / 1ps

module lwa_back import lwa_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  q_entry_type                   head,
   input  q_status_type                  q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_updated,
   output logic                          rsp_final_res,
   output logic                          rsp_short_row
);

   logic                          valid_ff, valid_in;
   logic signed [SAMPLE_BITS-1:0] updated_ff, updated_in;
   logic                          final_ff, final_in;
   logic                          short_ff, short_in;
   logic [1:0]                    rep_ff, rep_in;
   logic                          load;
   logic                          last_rep;

   assign load     = !valid_ff || !rsp_stall;
   assign last_rep = rep_ff == head.reps - 2'd1;
   assign pop      = load && q_status.not_empty && last_rep;

   always_comb begin
      valid_in   = valid_ff;
      updated_in = updated_ff;
      final_in   = final_ff;
      short_in   = short_ff;
      rep_in     = rep_ff;
      if (load) begin
         valid_in = q_status.not_empty;
         if (q_status.not_empty) begin
            updated_in = head.value;
            final_in   = head.row_last && last_rep;
            short_in   = head.short_row;
            rep_in     = last_rep ? 2'd0 : rep_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rep_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         rep_ff   <= rep_in;
      end
      updated_ff <= updated_in;
      final_ff   <= final_in;
      short_ff   <= short_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_updated   = updated_ff;
   assign rsp_final_res = final_ff;
   assign rsp_short_row = short_ff;

endmodule

[hw/rtl/lax_wendroff_advection_step_top.sv]
// Top level of the streaming Lax-Wendroff advection step.
`timescale 1ns / 1ps

// One grid row streams in as one sample per transfer, the last marked by
// req_row_end, and the new densities stream out in grid order with
// rsp_final_res on the last one of the row. The block takes one sample per
// cycle while req_stall is low: each sample passes through the registered
// difference stage and the registered multiplier stage of the front end, then
// the queue and then the output register, from which each result leaves when
// rsp_stall is low. The output runs at one result per cycle while rsp_stall is
// low, so the sustained rate is one sample per cycle, except that the third
// sample and the last sample of a row each produce two results (three for a
// three-point row) and hold the output for each of them. The four-entry queue
// reserves a slot for every entry still in the two front-end stages and stalls
// the input while they would not fit, so under a continuous stream the extra
// results stall the input, and gaps in the input let the queue drain. A row
// of fewer than three points yields a single zero result with rsp_short_row
// set. The user must write the coefficients through the csr_ port only while
// the block is idle; the block itself does not enforce this. Their reset
// values are a quarter and an eighth.

module lax_wendroff_advection_step_top import lwa_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_row_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_updated,
   output logic                          rsp_final_res,
   output logic                          rsp_short_row,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [COEF_BITS-1:0]          csr_wdata
);

   // Coefficient registers, both unsigned with fifteen fraction bits.
   logic [COEF_BITS-1:0] half_courant_ff, half_courant_in;
   logic [COEF_BITS-1:0] half_courant_sq_ff, half_courant_sq_in;

   logic         push;
   logic         pop;
   q_entry_type  push_entry;
   q_entry_type  head;
   q_status_type q_status;

   always_comb begin
      half_courant_in    = half_courant_ff;
      half_courant_sq_in = half_courant_sq_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_HALF_COURANT:    half_courant_in    = csr_wdata;
            CSR_HALF_COURANT_SQ: half_courant_sq_in = csr_wdata;
            default:             half_courant_in    = half_courant_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_courant_ff    <= HALF_COURANT_RESET;
         half_courant_sq_ff <= HALF_COURANT_SQ_RESET;
      end else begin
         half_courant_ff    <= half_courant_in;
         half_courant_sq_ff <= half_courant_sq_in;
      end
   end

   // The front end keeps the three-point window and computes each update.
   lwa_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_row_end     (req_row_end),
      .half_courant    (half_courant_ff),
      .half_courant_sq (half_courant_sq_ff),
      .q_status        (q_status),
      .push            (push),
      .push_entry      (push_entry)
   );

   // Each queued entry carries one value and how many times it is sent.
   lwa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // The back end repeats the value for the boundary copies and drives the output.
   lwa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_updated   (rsp_updated),
      .rsp_final_res (rsp_final_res),
      .rsp_short_row (rsp_short_row)
   );

endmodule

[sim/lax_wendroff_advection_step_top_test.sv]
// Self-checking testbench for the streaming Lax-Wendroff advection step.
`timescale 1ns / 1ps

// The testbench streams grid rows into the block and checks every new density
// that comes out. A predictor of the block keeps its own stencil window and
// coefficient copies. On each accepted input transfer it appends the results
// that the sample causes to a queue of pending densities. A checking process
// compares each accepted output transfer, field by field, with the oldest
// entry of that queue.
//
// The sender works in bursts of random length with random gaps between them.
// The receiver stalls in modes that change at random: never, sometimes, mostly
// or on a fixed beat. The coefficients are written only when the block is
// idle, that is with no result pending, after a few settling cycles, and
// always at a row boundary.

module lax_wendroff_advection_step_top_test;
   import lwa_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   // The pipeline is three stages deep and the queue four entries deep, and
   // the settling wait is meant to cover anything still in flight.
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS   = 105;

   localparam logic [COEF_BITS-1:0] COEF_MAX  = '1;
   localparam logic [COEF_BITS-1:0] COEF_HALF = COEF_BITS'(1 << (COEF_BITS - 1));
   localparam logic [COEF_BITS-1:0] COEF_ZERO = '0;

   localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP = SAMPLE_HI[SAMPLE_BITS-1:0];
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOT = SAMPLE_LO[SAMPLE_BITS-1:0];

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] updated;
      logic                          final_res;
      logic                          short_row;
   } density_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          req_row_end = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_updated;
   logic                          rsp_final_res;
   logic                          rsp_short_row;
   logic                          csr_write_en = 1'b0;
   logic                          csr_index = CSR_HALF_COURANT;
   logic [COEF_BITS-1:0]          csr_wdata = '0;

   // These are the predictor's copies of the coefficients and of the
   // stencil window.
   logic [COEF_BITS-1:0]          coef_h = HALF_COURANT_RESET;
   logic [COEF_BITS-1:0]          coef_g = HALF_COURANT_SQ_RESET;
   logic signed [SAMPLE_BITS-1:0] win_left = '0;
   logic signed [SAMPLE_BITS-1:0] win_centre = '0;
   int                            window_fill = 0;

   density_result_type pending_densities[$];
   int                 mismatches = 0;
   int                 cycle_count = 0;
   int                 burst_left = 0;
   int                 stall_mode = 0;
   int                 stall_mode_left = 0;

   lax_wendroff_advection_step_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .req_row_end   (req_row_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_updated   (rsp_updated),
      .rsp_final_res (rsp_final_res),
      .rsp_short_row (rsp_short_row),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The watchdog stops a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lax_wendroff_advection_step_top: mismatch");
         $finish;
      end
   end

   // This computes the new centre density of one window. The floor shifts
   // come from arithmetic shifts of the signed products, and the sum is then
   // clamped to the sample range.
   function automatic logic signed [SAMPLE_BITS-1:0] advect_centre(
      input logic signed [SAMPLE_BITS-1:0] l,
      input logic signed [SAMPLE_BITS-1:0] c,
      input logic signed [SAMPLE_BITS-1:0] r);
      longint flux, curvature, y;
      flux      = longint'(coef_h) * (longint'(r) - longint'(l));
      curvature = longint'(coef_g) * (longint'(r) - 2 * longint'(c) + longint'(l));
      y = longint'(c) - (flux >>> COEF_BITS) + (curvature >>> COEF_BITS);
      if (y > SAMPLE_HI)
         y = SAMPLE_HI;
      else if (y < SAMPLE_LO)
         y = SAMPLE_LO;
      return y[SAMPLE_BITS-1:0];
   endfunction

   function automatic void expect_density(input logic signed [SAMPLE_BITS-1:0] v,
                                          input logic fin, input logic short_flag);
      density_result_type d;
      d.updated   = v;
      d.final_res = fin;
      d.short_row = short_flag;
      pending_densities.push_back(d);
   endfunction

   // This runs the predictor on one accepted sample. The third point of a row
   // also yields the copy for the left boundary, and the last point also
   // yields the copy for the right boundary. A row that ends before three
   // points yields one zero result with the short-row flag set.
   function automatic void predict_sample(input logic signed [SAMPLE_BITS-1:0] x,
                                          input logic last);
      logic signed [SAMPLE_BITS-1:0] y;
      if (window_fill < 2) begin
         if (last) begin
            expect_density('0, 1'b1, 1'b1);
            win_left    = '0;
            win_centre  = '0;
            window_fill = 0;
         end else begin
            win_left    = win_centre;
            win_centre  = x;
            window_fill = window_fill + 1;
         end
      end else begin
         y = advect_centre(win_left, win_centre, x);
         if (window_fill == 2)
            expect_density(y, 1'b0, 1'b0);
         expect_density(y, 1'b0, 1'b0);
         if (last) begin
            expect_density(y, 1'b1, 1'b0);
            win_left    = '0;
            win_centre  = '0;
            window_fill = 0;
         end else begin
            win_left    = win_centre;
            win_centre  = x;
            window_fill = 3;
         end
      end
   endfunction

   // This sends one sample and waits for its transfer. Before each burst the
   // sender may stay idle for a random gap. The task is always entered just
   // after a rising edge, and it returns at the edge of the transfer.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left  = burst_left - 1;
      req_valid   <= 1'b1;
      req_sample  <= x;
      req_row_end <= last;
      do @(posedge clock); while (req_stall);
      predict_sample(x, last);
   endtask

   // This holds the sender back until every expected density has arrived,
   // and then lets the pipeline settle.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_densities.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // This writes both coefficients on consecutive cycles. The write enable
   // stays high across both writes and is lowered once afterwards.
   task automatic write_coefficients(input logic [COEF_BITS-1:0] h,
                                     input logic [COEF_BITS-1:0] g);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_HALF_COURANT;
      csr_wdata    <= h;
      @(posedge clock);
      coef_h = h;
      csr_index    <= CSR_HALF_COURANT_SQ;
      csr_wdata    <= g;
      @(posedge clock);
      coef_g = g;
      csr_write_en <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_TOP;
         1:       return SAMPLE_BOT;
         2, 3:    return SAMPLE_BITS'($urandom_range(0, 400)) - SAMPLE_BITS'(200);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic send_row(input int len);
      for (int i = 0; i < len; i++)
         send_sample(pick_sample(), i == len - 1);
   endtask

   // These rows use the reset coefficients, a quarter and an eighth. The
   // rows are of three and four points.
   task automatic test_reset_coefficients();
      send_sample(16'sd1000, 1'b0);
      send_sample(-16'sd2000, 1'b0);
      send_sample(16'sd3000, 1'b1);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd8191, 1'b0);
      send_sample(-16'sd8192, 1'b0);
      send_sample(16'sd4000, 1'b1);
   endtask

   // These are rows of one and of two points. A full row follows them to
   // show that the window restarts cleanly.
   task automatic test_short_rows();
      send_sample(16'sd5, 1'b1);
      send_sample(-16'sd7, 1'b0);
      send_sample(16'sd12, 1'b1);
      send_sample(SAMPLE_TOP, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(SAMPLE_BOT, 1'b1);
   endtask

   // These rows use the extreme coefficients with full-scale samples. The
   // full-width coefficients with alternating samples make the result saturate at
   // both bounds. The rows are sent with full-width coefficients, with zero
   // coefficients and with one half.
   task automatic test_coefficient_extremes();
      wait_for_idle();
      write_coefficients(COEF_MAX, COEF_MAX);
      send_sample(SAMPLE_TOP, 1'b0);
      send_sample(SAMPLE_BOT, 1'b0);
      send_sample(SAMPLE_TOP, 1'b0);
      send_sample(SAMPLE_BOT, 1'b1);
      wait_for_idle();
      write_coefficients(COEF_ZERO, COEF_ZERO);
      send_sample(SAMPLE_BOT, 1'b0);
      send_sample(SAMPLE_TOP, 1'b0);
      send_sample(SAMPLE_BOT, 1'b1);
      wait_for_idle();
      write_coefficients(COEF_HALF, COEF_HALF);
      send_sample(SAMPLE_BOT, 1'b0);
      send_sample(SAMPLE_TOP, 1'b0);
      send_sample(SAMPLE_TOP, 1'b1);
   endtask

   // These are random rows under several coefficient settings. Most rows are
   // of ordinary length, some are short and some are long. Every phase ends
   // on a row boundary, so that the next write finds the window empty.
   task automatic test_random_rows();
      int                   sent;
      int                   pick;
      int                   len;
      logic [COEF_BITS-1:0] h;
      logic [COEF_BITS-1:0] g;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_idle();
         case (phase)
            0: begin
               h = COEF_BITS'($urandom_range(0, COEF_HALF));
               g = COEF_BITS'($urandom_range(0, COEF_HALF));
            end
            1: begin
               h = COEF_HALF;
               g = COEF_ZERO;
            end
            2: begin
               h = COEF_BITS'($urandom);
               g = COEF_BITS'($urandom);
            end
            default: begin
               h = COEF_ZERO;
               g = COEF_HALF;
            end
         endcase
         write_coefficients(h, g);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               len = $urandom_range(1, 2);
            else if (pick == 1)
               len = $urandom_range(11, 40);
            else
               len = $urandom_range(3, 10);
            send_row(len);
            sent = sent + len;
         end
      end
   endtask

   // The receiver stalls on a pattern of its own. It switches at random
   // between no stall, light stalling, heavy stalling and stalls on a fixed beat.
   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      <= $urandom_range(0, 3);
         stall_mode_left <= $urandom_range(10, 80);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (cycle_count % 3 == 0);
      endcase
   end

   // Each output transfer is checked against the oldest pending density.
   always @(posedge clock) begin : check_densities
      density_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_densities.size() == 0) begin
            $error("unexpected result: updated %0d final_res %0b short_row %0b",
                   rsp_updated, rsp_final_res, rsp_short_row);
            mismatches++;
         end else begin
            want = pending_densities.pop_front();
            if (rsp_updated !== want.updated) begin
               $error("updated: expected %0d, actual %0d", want.updated, rsp_updated);
               mismatches++;
            end
            if (rsp_final_res !== want.final_res) begin
               $error("final_res: expected %0b, actual %0b", want.final_res, rsp_final_res);
               mismatches++;
            end
            if (rsp_short_row !== want.short_row) begin
               $error("short_row: expected %0b, actual %0b", want.short_row, rsp_short_row);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_coefficients();
      test_short_rows();
      test_coefficient_extremes();
      test_random_rows();
      // Once the last input transfer has been made, the testbench waits for
      // the remaining densities and for a quiet tail.
      wait_for_idle();
      if (mismatches == 0 && pending_densities.size() == 0)
         $display("lax_wendroff_advection_step_top: match");
      else
         $display("lax_wendroff_advection_step_top: mismatch");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/lwa_pkg.sv
hw/rtl/lwa_front.sv
hw/rtl/lwa_queue.sv
hw/rtl/lwa_back.sv
hw/rtl/lax_wendroff_advection_step_top.sv
sim/lax_wendroff_advection_step_top_test.sv
